/* hw/rtl/ais_pkg.sv */
// Shared types and constants for the active input slot table.
// Holds the slot count, field widths, request and register codes and the entry type.
// No dependencies; every other file of the block imports it.
package ais_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    // Fixed field widths of the stream payloads.
    localparam int WORD_W      = 32;
    localparam int REQ_W       = 3;
    localparam int SIDX_W      = 8;
    localparam int HIT_IDX_W   = 4;
    localparam int ECOUNT_W    = 5;
    localparam int CAP_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam int S_TDATA_W   = 136;
    localparam int S_TUSER_W   = REQ_W;
    localparam int M_TDATA_W   = 144;
    localparam int M_TUSER_W   = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH      = 3'd0,
        REQ_REMOVE_ID = 3'd1,
        REQ_REMOVE_IX = 3'd2,
        REQ_FIND      = 3'd3,
        REQ_GET       = 3'd4,
        REQ_CLEAR     = 3'd5
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY    = 1'b0,
        CFG_DEFAULT_TAG = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic        [WORD_W-1:0] id;
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic        [WORD_W-1:0] tag;
    } t_entry;

    // Per-cell update controls: load takes the pushed entry, shift takes the neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

/* hw/rtl/ais_slot_cell.sv */
// One slot of the table: holds an entry and compares its id against the search key.
// Depends on ais_pkg for the entry and control types.
module ais_slot_cell (
    input  logic              i_clk,
    input  ais_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  logic [31:0]       i_key,
    input  ais_pkg::t_entry   i_load_entry,
    input  ais_pkg::t_entry   i_next_entry,
    output ais_pkg::t_entry   o_entry,
    output logic              o_match
);
    import ais_pkg::*;

    t_entry r_entry;

    // A load wins over a shift: a push after a removal lands on the cell that shifted.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_load_entry;
        end else if (i_ctl.shift) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = i_valid && (r_entry.id == i_key);

endmodule

/* hw/rtl/ais_first_hit.sv */
// Priority encoder over the match flags of the slot row.
// Depends on ais_pkg for the slot count and index width.
module ais_first_hit (
    input  logic [ais_pkg::MAX_SLOTS-1:0] i_match,
    output logic                          o_found,
    output logic [ais_pkg::IDX_W-1:0]     o_index
);
    import ais_pkg::*;

    // Scanning downward leaves the lowest matching slot in the index.
    always_comb begin
        o_index = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = IDX_W'(i);
            end
        end
    end

    assign o_found = |i_match;

endmodule

/* hw/rtl/active_input_slot_table.sv */
// Top level of the active input slot table: request decode, slot row, result register.
// Depends on ais_pkg, ais_slot_cell and ais_first_hit.
//
//  Channel   Direction  Payload (low bit first)                           Handshake
//  s_axis    in         tuser: req_type; tdata: point_id, pos_x, pos_y,   tvalid/tready
//                       tag_in, slot_index
//  m_axis    out        tuser: hit; tdata: hit_index, out_id, out_x,      tvalid/tready
//                       out_y, out_tag, entry_count
//  cfg       in         index 0 capacity, index 1 default_tag             write enable only
//
// The slot row compares, shifts and loads in the cycle the request is accepted, and the
// result appears in the output register on the next cycle. A new request can be accepted
// every cycle while the result register can take it. Reset sets the count to zero,
// capacity to the slot count and the default tag to zero; slot contents are not cleared,
// since only slots below the count are read. When the result register is full and not
// taken, the input stalls until it drains.
module active_input_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: point_id[31:0], pos_x[63:32], pos_y[95:64], tag_in[127:96],
    //        slot_index[135:128]
    input  logic [ais_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [ais_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // Result stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: hit_index[3:0], out_id[35:4], out_x[67:36], out_y[99:68],
    //        out_tag[131:100], entry_count[136:132], zeros above
    output logic [ais_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: hit[0]
    output logic [ais_pkg::M_TUSER_W-1:0] m_axis_tuser,
    // Configuration writes.
    input  logic                        i_cfg_we,
    input  logic [ais_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ais_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ais_pkg::*;

    // Unpacked request fields.
    logic [WORD_W-1:0] req_id;
    t_entry            req_entry;
    logic [SIDX_W-1:0] req_sidx;
    t_req_type         req_type;

    assign req_id          = s_axis_tdata[31:0];
    assign req_entry.id    = s_axis_tdata[31:0];
    assign req_entry.x     = s_axis_tdata[63:32];
    assign req_entry.y     = s_axis_tdata[95:64];
    assign req_entry.tag   = s_axis_tdata[127:96];
    assign req_sidx        = s_axis_tdata[135:128];
    assign req_type        = t_req_type'(s_axis_tuser);

    // State and configuration registers.
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_capacity, n_capacity;
    logic [WORD_W-1:0] r_default_tag, n_default_tag;

    // Result register.
    logic              r_out_valid;
    logic              r_hit, n_hit;
    logic [HIT_IDX_W-1:0] r_hit_index, n_hit_index;
    t_entry            r_out, n_out;
    logic [ECOUNT_W-1:0] r_ecount, n_ecount;

    logic accept;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Slot row.
    t_entry    cell_entry [MAX_SLOTS];
    t_cell_ctl cell_ctl   [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] cell_valid;
    logic [MAX_SLOTS-1:0] cell_match;

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        t_entry next_entry;
        if (g == MAX_SLOTS - 1) begin : g_tail
            assign next_entry = cell_entry[g];
        end else begin : g_body
            assign next_entry = cell_entry[g + 1];
        end

        assign cell_valid[g] = CNT_W'(g) < r_count;

        ais_slot_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[g]),
            .i_valid      (cell_valid[g]),
            .i_key        (req_id),
            .i_load_entry (req_entry),
            .i_next_entry (next_entry),
            .o_entry      (cell_entry[g]),
            .o_match      (cell_match[g])
        );
    end

    logic             found;
    logic [IDX_W-1:0] found_idx;

    ais_first_hit u_first_hit (
        .i_match (cell_match),
        .o_found (found),
        .o_index (found_idx)
    );

    // Request decode. The removal index is the first match for id based requests and the
    // given slot for removal by index; a push then appends after the shortened table.
    logic             sidx_in_range;
    logic             do_remove;
    logic [IDX_W-1:0] rm_idx;
    logic [CNT_W-1:0] count_after_rm;
    logic             push_ok;

    assign sidx_in_range  = 32'(req_sidx) < 32'(r_count);
    assign count_after_rm = r_count - CNT_W'(do_remove);

    always_comb begin
        do_remove = 1'b0;
        rm_idx    = found_idx;
        push_ok   = 1'b0;
        unique case (req_type)
            REQ_PUSH: begin
                do_remove = found;
            end
            REQ_REMOVE_ID: begin
                do_remove = found;
            end
            REQ_REMOVE_IX: begin
                do_remove = sidx_in_range;
                rm_idx    = req_sidx[IDX_W-1:0];
            end
            default: begin
                do_remove = 1'b0;
            end
        endcase
        if (req_type == REQ_PUSH) begin
            push_ok = (count_after_rm < r_capacity) &&
                      (32'(count_after_rm) < MAX_SLOTS);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            cell_ctl[i].shift = accept && do_remove && (IDX_W'(i) >= rm_idx);
            cell_ctl[i].load  = accept && push_ok && (CNT_W'(i) == count_after_rm);
        end
    end

    // Result and count for the request at hand.
    t_entry            get_entry;
    logic [31:0]       hit_idx_wide;
    logic [31:0]       count_wide;
    logic [CNT_W-1:0]  req_count;

    assign get_entry = cell_entry[req_sidx[IDX_W-1:0]];

    always_comb begin
        n_hit        = 1'b0;
        hit_idx_wide = '0;
        n_out        = '0;
        req_count    = count_after_rm;
        unique case (req_type)
            REQ_PUSH: begin
                n_hit = push_ok;
                if (push_ok) begin
                    req_count = count_after_rm + CNT_W'(1);
                end
            end
            REQ_REMOVE_ID: begin
                n_hit = found;
            end
            REQ_REMOVE_IX: begin
                n_hit = sidx_in_range;
            end
            REQ_FIND: begin
                n_hit = found;
                if (found) begin
                    hit_idx_wide = 32'(found_idx);
                end
            end
            REQ_GET: begin
                if (sidx_in_range) begin
                    n_hit = 1'b1;
                    n_out = get_entry;
                end else begin
                    n_out.tag = r_default_tag;
                end
            end
            REQ_CLEAR: begin
                req_count = '0;
            end
            default: begin
                // Unused request codes change nothing and answer zeros apart from the entry count.
                n_hit = 1'b0;
            end
        endcase
        count_wide  = 32'(req_count);
        n_hit_index = hit_idx_wide[HIT_IDX_W-1:0];
        n_ecount    = count_wide[ECOUNT_W-1:0];
    end

    // Count and configuration. Writes must come only while idle, so that a capacity write and a
    // request never meet in one cycle; the block does not enforce this, and the write wins.
    logic [CAP_W-1:0] cap_wr;
    logic [CNT_W-1:0] cap_new;
    assign cap_wr  = i_cfg_data[CAP_W-1:0];
    assign cap_new = (32'(cap_wr) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cap_wr);

    always_comb begin
        n_count       = r_count;
        n_capacity    = r_capacity;
        n_default_tag = r_default_tag;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_CAPACITY: begin
                    // A zero capacity is ignored; a lower one drops the table's tail.
                    if (cap_wr != '0) begin
                        n_capacity = cap_new;
                        if (r_count > cap_new) begin
                            n_count = cap_new;
                        end
                    end
                end
                CFG_DEFAULT_TAG: begin
                    n_default_tag = i_cfg_data[WORD_W-1:0];
                end
            endcase
        end else if (accept) begin
            n_count = req_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_capacity    <= CNT_W'(MAX_SLOTS);
            r_default_tag <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_count       <= n_count;
            r_capacity    <= n_capacity;
            r_default_tag <= n_default_tag;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit       <= n_hit;
            r_hit_index <= n_hit_index;
            r_out       <= n_out;
            r_ecount    <= n_ecount;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {7'b0, r_ecount, r_out.tag, r_out.y, r_out.x, r_out.id,
                            r_hit_index};

endmodule

/* hw/rtl/ais_checker.sv */
// Port-level checks for the active input slot table, bound to the top level.
// Depends on ais_pkg and on the port list of active_input_slot_table.
module ais_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ais_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input logic [ais_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ais_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic [ais_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    input logic                            i_cfg_we,
    input logic [ais_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [ais_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ais_pkg::*;

    // A pending result is never withdrawn before it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Reset empties the result register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The reported count never exceeds the number of slots.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[136:132]) <= MAX_SLOTS)
        else $error("entry count beyond slot count");

    // Entry id and position fields are only filled by a get in range, which is a hit.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[99:4] == '0 && m_axis_tdata[3:0] == '0)
        else $error("miss carries entry data");

    // The table can only accept a request when its result slot is free or draining.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

endmodule

bind active_input_slot_table ais_checker u_ais_checker (.*);

/* verif/tb_active_input_slot_table.sv */
// Self-checking testbench for the active input slot table: stream driver, result monitor
// and a request-by-request table predictor. Depends on ais_pkg and the active_input_slot_table RTL.
module tb_active_input_slot_table;
    timeunit 1ns;
    timeprecision 1ps;
    import ais_pkg::*;

    // Request codes 6 and 7 are unused by the block and must act as no-ops.
    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int ID_POOL_N   = 20;

    // One request as the sender sees it.
    typedef struct {
        logic        [REQ_W-1:0]  kind;
        logic        [WORD_W-1:0] id;
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic        [WORD_W-1:0] tag;
        logic        [SIDX_W-1:0] idx;
    } t_slot_request;

    // One result as the block reports it.
    typedef struct {
        logic                        hit;
        logic        [HIT_IDX_W-1:0] hit_index;
        logic        [WORD_W-1:0]    id;
        logic signed [WORD_W-1:0]    x;
        logic signed [WORD_W-1:0]    y;
        logic        [WORD_W-1:0]    tag;
        logic        [ECOUNT_W-1:0]  count;
    } t_slot_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    active_input_slot_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table predictor. It mirrors the slot row, the count and both registers,
    // and is advanced once per accepted request, in acceptance order.
    // ------------------------------------------------------------------------
    t_entry          table_slots [MAX_SLOTS];
    int unsigned     table_count = 0;
    int unsigned     table_capacity = MAX_SLOTS;
    logic [WORD_W-1:0] table_default_tag = '0;

    t_slot_request   pending_requests [$];
    t_slot_result    expected_results [$];
    t_slot_request   current_request;

    int              failures = 0;
    int              requests_done = 0;
    int              results_checked = 0;
    int              pushes_dropped = 0;
    int              cycle_count = 0;

    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              hold_ticket = 0;
    int              hold_served = 0;
    int              hold_left = 0;

    logic [WORD_W-1:0] id_pool [ID_POOL_N];

    // Index of the first live slot holding this id, or -1.
    function automatic int slot_of_id(logic [WORD_W-1:0] id);
        for (int i = 0; i < int'(table_count); i++) begin
            if (table_slots[i].id == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Removing a slot shifts every later slot down by one, keeping the order.
    function automatic void close_slot(int unsigned pos);
        for (int unsigned i = pos; i + 1 < table_count; i++) begin
            table_slots[i] = table_slots[i + 1];
        end
        table_count--;
    endfunction

    function automatic t_slot_result apply_request(t_slot_request r);
        t_slot_result res;
        int           pos;
        res = '{hit: 1'b0, hit_index: '0, id: '0, x: '0, y: '0, tag: '0, count: '0};
        case (r.kind)
            REQ_PUSH: begin
                // A same-id entry always goes, even when the new one is then dropped.
                pos = slot_of_id(r.id);
                if (pos >= 0) begin
                    close_slot(pos);
                end
                if (table_count < table_capacity) begin
                    table_slots[table_count] = '{id: r.id, x: r.x, y: r.y, tag: r.tag};
                    table_count++;
                    res.hit = 1'b1;
                end else begin
                    pushes_dropped++;
                end
            end
            REQ_REMOVE_ID: begin
                pos = slot_of_id(r.id);
                if (pos >= 0) begin
                    close_slot(pos);
                    res.hit = 1'b1;
                end
            end
            REQ_REMOVE_IX: begin
                if (r.idx < table_count) begin
                    close_slot(r.idx);
                    res.hit = 1'b1;
                end
            end
            REQ_FIND: begin
                pos = slot_of_id(r.id);
                if (pos >= 0) begin
                    res.hit = 1'b1;
                    res.hit_index = pos[HIT_IDX_W-1:0];
                end
            end
            REQ_GET: begin
                if (r.idx < table_count) begin
                    res.hit = 1'b1;
                    res.id  = table_slots[r.idx].id;
                    res.x   = table_slots[r.idx].x;
                    res.y   = table_slots[r.idx].y;
                    res.tag = table_slots[r.idx].tag;
                end else begin
                    res.tag = table_default_tag;
                end
            end
            REQ_CLEAR: begin
                table_count = 0;
            end
            default: begin
            end
        endcase
        res.count = table_count[ECOUNT_W-1:0];
        return res;
    endfunction

    // Register writes as the block sees them: capacity keeps only its low five
    // bits, ignores zero, saturates at the slot count and clamps the table.
    function automatic void apply_reg_write(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        int unsigned c;
        if (r == CFG_CAPACITY) begin
            c = 32'(v[CAP_W-1:0]);
            if (c != 0) begin
                table_capacity = (c > MAX_SLOTS) ? MAX_SLOTS : c;
                if (table_count > table_capacity) begin
                    table_count = table_capacity;
                end
            end
        end else begin
            table_default_tag = v;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. It offers the next pending request unless the current
    // phase asks for a gap, and updates the predictor on each handshake.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        t_slot_request nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_request(current_request));
                requests_done++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_requests.pop_front();
                    current_request = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.idx, nxt.tag, nxt.y, nxt.x, nxt.id};
                    s_axis_tuser  <= nxt.kind;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Random stalls per phase, plus a long hold-off whenever
    // the stimulus raises the hold ticket, so the block fills and stalls.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_ticket != hold_served) begin
            hold_served   <= hold_ticket;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic int field_differs(string name, logic [WORD_W-1:0] want,
                                         logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // Result monitor. Each accepted result is compared with the oldest
    // outstanding prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_slot_result want;
        int           bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                failures++;
            end else begin
                want = expected_results.pop_front();
                bad  = field_differs("hit", 32'(want.hit), 32'(m_axis_tuser[0]));
                bad += field_differs("hit_index", 32'(want.hit_index),
                                     32'(m_axis_tdata[3:0]));
                bad += field_differs("out_id", want.id, m_axis_tdata[35:4]);
                bad += field_differs("out_x", want.x, m_axis_tdata[67:36]);
                bad += field_differs("out_y", want.y, m_axis_tdata[99:68]);
                bad += field_differs("out_tag", want.tag, m_axis_tdata[131:100]);
                bad += field_differs("entry_count", 32'(want.count),
                                     32'(m_axis_tdata[136:132]));
                if (bad != 0) begin
                    failures++;
                end
                results_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_req(logic [REQ_W-1:0] kind, logic [WORD_W-1:0] id,
                             logic [WORD_W-1:0] x, logic [WORD_W-1:0] y,
                             logic [WORD_W-1:0] tag, logic [SIDX_W-1:0] idx);
        t_slot_request r;
        r = '{kind: kind, id: id, x: x, y: y, tag: tag, idx: idx};
        pending_requests.push_back(r);
    endtask

    // Mostly ids from a small pool so that finds, removals and duplicate
    // pushes hit; indexes mostly near the table size, sometimes anywhere.
    task automatic queue_random(int n);
        int                  p;
        logic [REQ_W-1:0]    kind;
        logic [WORD_W-1:0]   id;
        logic [SIDX_W-1:0]   idx;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 34)      kind = REQ_PUSH;
            else if (p < 46) kind = REQ_REMOVE_ID;
            else if (p < 57) kind = REQ_REMOVE_IX;
            else if (p < 71) kind = REQ_FIND;
            else if (p < 89) kind = REQ_GET;
            else if (p < 93) kind = REQ_CLEAR;
            else             kind = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
            id  = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_N - 1)]
                                               : $urandom;
            idx = ($urandom_range(0, 99) < 80) ? SIDX_W'($urandom_range(0, 17))
                                               : SIDX_W'($urandom_range(0, 255));
            queue_req(kind, id, $urandom, $urandom, $urandom, idx);
        end
    endtask

    // Returns once every request has been taken and answered; only then may a
    // register be written.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [CFG_DATA_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg_write(r, v);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_N; i++) begin
            id_pool[i] = $urandom;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration: empty-table corner cases,
        // extreme field values, a duplicate push, lookups in and out of range,
        // the unused request codes and clear.
        set_idling(0, 0);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd0);
        queue_req(REQ_FIND,      32'd5, '0, '0, '0, '0);
        queue_req(REQ_REMOVE_ID, 32'd5, '0, '0, '0, '0);
        queue_req(REQ_REMOVE_IX, '0, '0, '0, '0, 8'd0);
        queue_req(REQ_PUSH,      '0, 32'h8000_0000, 32'h7fff_ffff, '0, '1);
        queue_req(REQ_PUSH,      '1, 32'h7fff_ffff, 32'h8000_0000, '1, '0);
        queue_req(REQ_PUSH,      32'd5, '1, '0, 32'h1234_5678, '0);
        queue_req(REQ_PUSH,      '0, 32'd1, 32'd2, 32'd3, '0);
        queue_req(REQ_FIND,      '1, '1, '1, '1, '1);
        queue_req(REQ_FIND,      '0, '0, '0, '0, '0);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd0);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd2);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd3);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd255);
        queue_req(REQ_REMOVE_IX, '0, '0, '0, '0, 8'd255);
        queue_req(REQ_REMOVE_IX, '0, '0, '0, '0, 8'd1);
        queue_req(REQ_REMOVE_ID, '1, '0, '0, '0, '0);
        queue_req(REQ_UNUSED_A,  '1, '1, '1, '1, '1);
        queue_req(REQ_UNUSED_B,  '0, '0, '0, '0, '0);
        queue_req(REQ_CLEAR,     '0, '0, '0, '0, '0);
        queue_req(REQ_GET,       '0, '0, '0, '0, 8'd0);
        wait_drained();

        // Single slot: the second distinct push is dropped, a duplicate push
        // still replaces, and an out-of-range get returns the all-ones tag.
        write_reg(CFG_CAPACITY, 32'd1);
        write_reg(CFG_DEFAULT_TAG, 32'hffff_ffff);
        queue_req(REQ_PUSH, id_pool[2], 32'd10, 32'd20, 32'd30, '0);
        queue_req(REQ_PUSH, id_pool[3], 32'd11, 32'd21, 32'd31, '0);
        queue_req(REQ_PUSH, id_pool[2], 32'd12, 32'd22, 32'd32, '0);
        queue_req(REQ_GET,  '0, '0, '0, '0, 8'd0);
        queue_req(REQ_GET,  '0, '0, '0, '0, 8'd1);
        queue_random(40);
        wait_drained();

        // Capacity 31 saturates to the slot count; the sender idles often.
        write_reg(CFG_CAPACITY, 32'd31);
        write_reg(CFG_DEFAULT_TAG, 32'ha5a5_5a5a);
        set_idling(65, 0);
        queue_random(110);
        // Leave twelve entries behind so the next capacity write must clamp.
        queue_req(REQ_CLEAR, '0, '0, '0, '0, '0);
        for (int i = 0; i < 12; i++) begin
            queue_req(REQ_PUSH, 32'h8000_0000 + i, $urandom, $urandom, $urandom, '0);
        end
        wait_drained();

        // A zero capacity is ignored; then eight (upper data bits set) clamps
        // the table. The receiver stalls often.
        write_reg(CFG_CAPACITY, 32'd0);
        write_reg(CFG_CAPACITY, 32'hffff_ffe8);
        set_idling(0, 65);
        queue_req(REQ_GET, '0, '0, '0, '0, 8'd7);
        queue_req(REQ_GET, '0, '0, '0, '0, 8'd8);
        queue_random(115);
        wait_drained();

        // Full size again, random default tag, both sides idling, and one
        // long receiver hold-off while the sender keeps offering requests.
        write_reg(CFG_CAPACITY, 32'd17);
        write_reg(CFG_DEFAULT_TAG, $urandom);
        set_idling(22, 22);
        queue_random(120);
        hold_ticket <= hold_ticket + 1;
        wait_drained();

        // Small table with no idling, so full-table pushes are frequent.
        write_reg(CFG_CAPACITY, 32'd3);
        write_reg(CFG_DEFAULT_TAG, 32'd0);
        set_idling(0, 0);
        queue_random(100);
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d requests over six register settings (capacity 1 to 16).",
                 requests_done);
        $display("Checked %0d results; %0d pushes were dropped on a full table.",
                 results_checked, pushes_dropped);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
